@@ hdl/packet_line_frame_reassembler_core_assert.svh @@
`ifndef PACKET_LINE_FRAME_REASSEMBLER_CORE_ASSERT_SVH
`define PACKET_LINE_FRAME_REASSEMBLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plfr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PLFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plfr: next-cycle check failed");

`endif

@@ hdl/plfr_pkg.sv @@
package plfr_pkg;

  localparam int FRAME_BUF_LEN = 64;
  localparam int ADDR_W = $clog2(FRAME_BUF_LEN);

  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] MASK_RESET = 8'h01;

  // Largest byte count a frame may hold before it is dropped.
  localparam logic [ADDR_W-1:0] CNT_MAX = ADDR_W'(FRAME_BUF_LEN - 1);

  typedef enum logic {
    RD_IDLE,
    RD_RUN
  } plfr_rd_state_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] last_addr;
  } plfr_start_t;

endpackage

@@ hdl/plfr_frame_ram.sv @@
module plfr_frame_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [plfr_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic                        re,
  input  logic [plfr_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                  rdata
);
  import plfr_pkg::*;

  logic [7:0] mem [FRAME_BUF_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/plfr_readout.sv @@
module plfr_readout (
  input  logic                        clk,
  input  logic                        rst,
  input  plfr_pkg::plfr_start_t       start_req,
  output logic                        busy,
  output logic                        rd_en,
  output logic [plfr_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        frame_valid,
  input  logic                        frame_stall,
  output logic [7:0]                  frame_byte,
  output logic                        frame_last
);
  import plfr_pkg::*;
  `include "packet_line_frame_reassembler_core_assert.svh"

  plfr_rd_state_t state, state_next;
  logic [ADDR_W-1:0] last_addr;
  logic pend;
  logic pend_last;
  logic load;
  logic at_end;

  // The RAM read register holds a byte (pend) until the output register can take it.
  assign load = pend && (!frame_valid || !frame_stall);
  assign at_end = (rd_addr == last_addr);
  assign busy = (state == RD_RUN);

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    case (state)
      RD_IDLE: begin
        if (start_req.start) begin
          state_next = RD_RUN;
        end
      end
      RD_RUN: begin
        rd_en = !pend || load;
        if (rd_en && at_end) begin
          state_next = RD_IDLE;
        end
      end
      default: begin
        state_next = RD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == RD_IDLE && start_req.start) begin
      rd_addr <= '0;
      last_addr <= start_req.last_addr;
    end else if (rd_en) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (rd_en) begin
      pend_last <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        frame_valid <= 1'b1;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= rd_data;
      frame_last <= pend_last;
    end
  end

  `PLFR_ASSERT_NOW(a_read_only_running, rd_en, state == RD_RUN)
  `PLFR_ASSERT_NOW(a_start_only_idle, start_req.start, state == RD_IDLE)
  `PLFR_ASSERT_NEXT(a_pend_held, pend && !load, pend)
  `PLFR_ASSERT_NEXT(a_end_goes_idle, rd_en && at_end, state == RD_IDLE)

endmodule

@@ hdl/packet_line_frame_reassembler_core.sv @@
// Packet line frame reassembler.
// Input channel: one received packet byte per beat (packet_byte, is_header),
// with in_valid / in_stall. Output channel: one frame byte per beat
// (frame_byte, frame_last) with frame_valid / frame_stall; frame_last marks
// the newline that closes a frame.
// The header mask register is written with start_flag_mask_we and
// start_flag_mask_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce. It resets to 1.
// An accepted input beat writes at most one byte into the frame RAM.
// A newline beat starts a readout of the whole frame: the input stalls
// while the RAM is read in order, and each byte passes the RAM read
// register and then the output register. Readout streams one byte per
// cycle while frame_stall is low, through the single RAM read port.
// When frame_stall is high the readout holds its RAM read and waits; no byte
// is lost. Reset clears sync, the byte count and the readout; the RAM content
// is not cleared and is only read where the current frame wrote it.
module packet_line_frame_reassembler_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start_flag_mask_we,
  input  logic [7:0] start_flag_mask_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] packet_byte,
  input  logic       is_header,
  output logic       frame_valid,
  input  logic       frame_stall,
  output logic [7:0] frame_byte,
  output logic       frame_last
);
  import plfr_pkg::*;

  logic [7:0] start_flag_mask;
  logic [ADDR_W-1:0] frame_count;
  logic in_sync;
  logic skip_packet_rest;

  logic accept;
  logic payload;
  logic store;
  logic busy;
  logic rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0] rd_data;
  plfr_start_t start_req;

  assign in_stall = busy;
  assign accept = in_valid && !busy;
  assign payload = accept && !is_header && in_sync && !skip_packet_rest
                   && (packet_byte != ZERO_BYTE);
  assign store = payload && (frame_count < CNT_MAX);
  assign start_req.start = store && (packet_byte == NEWLINE_BYTE);
  assign start_req.last_addr = frame_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_flag_mask <= MASK_RESET;
    end else if (start_flag_mask_we) begin
      start_flag_mask <= start_flag_mask_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      in_sync <= 1'b0;
      skip_packet_rest <= 1'b0;
    end else if (accept) begin
      if (is_header) begin
        skip_packet_rest <= 1'b0;
        if ((packet_byte & start_flag_mask) != 8'h00) begin
          frame_count <= '0;
          in_sync <= 1'b1;
        end
      end else if (in_sync && !skip_packet_rest) begin
        if (packet_byte == ZERO_BYTE) begin
          skip_packet_rest <= 1'b1;
        end else if (!store || start_req.start) begin
          // Overflow drops the frame; a newline closes it when it requests the readout.
          frame_count <= '0;
          in_sync <= 1'b0;
        end else begin
          frame_count <= frame_count + 1'b1;
        end
      end
    end
  end

  plfr_frame_ram u_ram (
    .clk   (clk),
    .we    (store),
    .waddr (frame_count),
    .wdata (packet_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  plfr_readout u_readout (
    .clk         (clk),
    .rst         (rst),
    .start_req   (start_req),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last)
  );

endmodule

@@ tb/tb_packet_line_frame_reassembler_core.sv @@
module tb_packet_line_frame_reassembler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import plfr_pkg::*;

  // No accepted beat on either channel for this many cycles means a hang.
  localparam int IDLE_LIMIT = 2000;
  // Cycles left after the last frame beat before the mask is rewritten or the run ends.
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       mask_we = 1'b0;
  logic [7:0] mask_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] packet_byte = 8'h00;
  logic       is_header = 1'b0;
  logic       frame_valid;
  logic       frame_stall = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_last;

  rx_beat_t    rx_pending_q[$];
  frame_beat_t frame_expect_q[$];

  // Shadow of the reassembler state.
  logic [7:0]        line_buf [FRAME_BUF_LEN];
  logic [ADDR_W-1:0] line_len = '0;
  logic              synced = 1'b0;
  logic              skip_rest = 1'b0;
  logic [7:0]        hdr_mask = MASK_RESET;

  logic quiet = 1'b0;
  int   send_gap = 0;
  int   recv_wait = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;

  packet_line_frame_reassembler_core u_top (
    .clk                   (clk),
    .rst                   (rst),
    .start_flag_mask_we    (mask_we),
    .start_flag_mask_wdata (mask_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .packet_byte           (packet_byte),
    .is_header             (is_header),
    .frame_valid           (frame_valid),
    .frame_stall           (frame_stall),
    .frame_byte            (frame_byte),
    .frame_last            (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Advances the shadow state by one received byte and queues any frame it completes.
  function automatic void reassemble_byte(input logic [7:0] b, input logic hdr);
    if (hdr) begin
      skip_rest = 1'b0;
      if ((b & hdr_mask) != 8'h00) begin
        line_len = '0;
        synced = 1'b1;
      end
    end else if (synced && !skip_rest) begin
      if (b == ZERO_BYTE) begin
        skip_rest = 1'b1;
      end else if (line_len >= CNT_MAX) begin
        line_len = '0;
        synced = 1'b0;
      end else begin
        line_buf[line_len] = b;
        line_len = line_len + 1'b1;
        if (b == NEWLINE_BYTE) begin
          for (int k = 0; k < int'(line_len); k++) begin
            frame_expect_q.push_back({line_buf[k], 1'(k + 1 == int'(line_len))});
          end
          line_len = '0;
          synced = 1'b0;
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("%0t: frame %s mismatch, got %h, expected %h", $time, what, got, want);
  endtask

  // Input driver.
  always @(posedge clk) begin
    rx_beat_t nxt;
    logic     take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        reassemble_byte(packet_byte, is_header);
      end
      if (!in_valid || take) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_pending_q.size() != 0) begin
          nxt = rx_pending_q.pop_front();
          packet_byte <= nxt.data;
          is_header <= nxt.hdr;
          in_valid <= 1'b1;
          send_gap = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Frame monitor.
  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      frame_stall <= 1'b0;
    end else begin
      if (frame_valid && !frame_stall) begin
        if (frame_expect_q.size() == 0) begin
          report_mismatch("unexpected beat", frame_byte, 8'h00);
        end else begin
          want = frame_expect_q.pop_front();
          if (frame_byte !== want.data) begin
            report_mismatch("byte", frame_byte, want.data);
          end
          if (frame_last !== want.last) begin
            report_mismatch("last", {7'b0, frame_last}, {7'b0, want.last});
          end
        end
        recv_wait = draw_wait();
      end else if (frame_valid && recv_wait > 0) begin
        recv_wait--;
      end
      frame_stall <= (recv_wait != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (frame_valid && !frame_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_rx(input logic [7:0] b, input logic hdr);
    rx_pending_q.push_back({b, hdr});
  endtask

  function automatic logic [7:0] start_header();
    int bit_sel;
    if (hdr_mask == 8'h00) begin
      return 8'($urandom_range(0, 255));
    end
    bit_sel = $urandom_range(0, 7);
    while (!hdr_mask[bit_sel]) begin
      bit_sel = $urandom_range(0, 7);
    end
    return 8'($urandom_range(0, 255)) | (8'h01 << bit_sel);
  endfunction

  function automatic logic [7:0] plain_header();
    return 8'($urandom_range(0, 255)) & ~hdr_mask;
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    while (b == NEWLINE_BYTE) begin
      b = 8'($urandom_range(1, 255));
    end
    return b;
  endfunction

  // One frame spread over packets: a newline close, an overflow drop, or an abandoned frame.
  task automatic gen_frame();
    int kind;
    int len;
    kind = $urandom_range(0, 19);
    len = (kind == 0) ? 62 : (kind == 1) ? 63 : int'($urandom_range(0, 12));
    push_rx(start_header(), 1'b1);
    for (int i = 0; i < len; i++) begin
      push_rx(payload_byte(), 1'b0);
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          push_rx(ZERO_BYTE, 1'b0);
          repeat ($urandom_range(0, 3)) push_rx(8'($urandom_range(0, 255)), 1'b0);
        end
        push_rx(plain_header(), 1'b1);
      end
    end
    if (kind == 1) begin
      push_rx(payload_byte(), 1'b0);
    end else if (kind != 2) begin
      push_rx(NEWLINE_BYTE, 1'b0);
    end
  endtask

  task automatic drain();
    while (rx_pending_q.size() != 0 || in_valid || frame_expect_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] mask, input logic calm, input int target);
    @(posedge clk);
    mask_we <= 1'b1;
    mask_wdata <= mask;
    hdr_mask = mask;
    @(posedge clk);
    mask_we <= 1'b0;
    quiet = calm;
    while (rx_pending_q.size() < target) begin
      if ($urandom_range(0, 4) == 0) begin
        push_rx(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        gen_frame();
      end
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset mask.
    push_rx(8'h55, 1'b0);          // payload before any header
    push_rx(8'h00, 1'b1);          // header without start flag, out of sync
    push_rx(NEWLINE_BYTE, 1'b0);   // newline while out of sync
    push_rx(8'h01, 1'b1);
    push_rx(8'hFF, 1'b0);
    push_rx(8'h01, 1'b0);
    push_rx(8'h80, 1'b0);
    push_rx(ZERO_BYTE, 1'b0);      // ends this packet's payload
    push_rx(NEWLINE_BYTE, 1'b0);
    push_rx(8'h7E, 1'b0);
    push_rx(8'hFE, 1'b1);          // continuation header keeps the frame open
    push_rx(8'h41, 1'b0);
    push_rx(NEWLINE_BYTE, 1'b0);
    push_rx(8'hFF, 1'b1);
    push_rx(NEWLINE_BYTE, 1'b0);   // frame of just the newline
    push_rx(8'h03, 1'b1);
    push_rx(8'h11, 1'b0);
    push_rx(8'h22, 1'b0);
    push_rx(8'h01, 1'b1);          // new start discards the partial frame
    push_rx(8'h33, 1'b0);
    push_rx(NEWLINE_BYTE, 1'b0);
    push_rx(8'h44, 1'b0);
    drain();

    run_phase(8'hFF, 1'b0, 40);
    run_phase(8'h80, 1'b1, 30);
    run_phase(8'($urandom_range(1, 255)), 1'b0, 40);
    run_phase(8'h00, 1'b0, 20);
    run_phase(8'($urandom_range(1, 255)), 1'b1, 30);
    run_phase(MASK_RESET, 1'b0, 40);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
